// ===== design/mts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int unsigned NOTE_SLOTS_DEF    = 256;
   localparam int unsigned TICK_CLOCK_HZ_DEF = 1000000;

   localparam int IDX_W      = 8;
   localparam int FREQ_W     = 16;
   localparam int DUR_W      = 16;
   localparam int SF_W       = 8;
   localparam int LEN_W      = 9;
   localparam int PERIOD_W   = 20;
   localparam int CMP_W      = 19;
   localparam int POS_W      = 8;
   localparam int HOLD_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_FACTOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MELODY_LENGTH = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_PDIV,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== design/melody_tone_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// Note table player: tick beats step the melody, write beats fill the table.
// ----------------------------------------------------------------------------
// A tick beat that lands inside a held note only counts the hold down and
// gives no result. A tick beat that starts a note has its result in the output
// register after these steps: one table read, one step for the hold count, one
// quotient bit per cycle from the restoring divider, one step to see the
// divider finish and one step to load the output register. The next beat can
// be taken in the cycle after the output register is loaded. A rest skips the
// divider. While the output register still holds an unread result, a finished
// note waits in the emit step until the register is free. A write beat is
// taken in the idle state and fills one table slot. The output register holds
// a finished result while the next beat is taken. The note table comes up
// unwritten; playing a slot never written gives undefined tone values.
// ----------------------------------------------------------------------------
module melody_tone_sequencer
   import mts_pkg::*;
#(
   parameter int unsigned NOTE_SLOTS    = NOTE_SLOTS_DEF,
   parameter int unsigned TICK_CLOCK_HZ = TICK_CLOCK_HZ_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // note_index, note_freq, note_duration
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tone_period, tone_compare, played_position, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IW  = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int LW  = ($clog2(NOTE_SLOTS + 1) > LEN_W) ? $clog2(NOTE_SLOTS + 1) : LEN_W;
   localparam int TW  = $clog2(TICK_CLOCK_HZ + 1);
   localparam int QW  = (TW > PERIOD_W) ? TW : PERIOD_W;
   localparam int CW  = $clog2(TW + 1);
   localparam int DVW = FREQ_W;

   state_type state_ff, state_in;

   logic [SF_W-1:0]     slow_ff, slow_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [IW-1:0]       play_pos_ff, play_pos_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic [PERIOD_W-1:0] last_period_ff, last_period_in;
   logic                rest_ff, rest_in;

   logic [DVW-1:0]      rem_ff, rem_in;
   logic [TW-1:0]       quo_ff, quo_in;
   logic [DVW-1:0]      dvs_ff, dvs_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic [CMP_W-1:0]    rsp_cmp_ff, rsp_cmp_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   logic [FREQ_W+DUR_W-1:0] note_mem [NOTE_SLOTS];
   logic [FREQ_W+DUR_W-1:0] rd_data_ff;

   logic              accept;
   logic              out_free;
   logic              emit_fire;
   logic              div_done;
   logic              div_load;
   logic [TW-1:0]     div_dividend;
   logic [DVW-1:0]    div_divisor;
   logic              mem_we;
   logic [IW-1:0]     wr_slot;
   logic [LW-1:0]     eff_len;
   logic [FREQ_W-1:0] rd_freq;
   logic [DUR_W-1:0]  rd_dur;
   logic [DUR_W-1:0]  dur_eff;
   logic [SF_W-1:0]   sf_eff;
   logic [HOLD_W-1:0] hold_prod;
   logic [DVW:0]      rem_sh;
   logic [DVW:0]      rem_diff;
   logic              rem_ge;
   logic [QW-1:0]     quo_ext;
   logic [PERIOD_W-1:0] new_period;
   logic [LW-1:0]     pos_next;

   // slot index modulo the table depth by constant compare and subtract
   function automatic logic [IW-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      r = idx;
      for (int k = IDX_W - 1; k >= 0; k--) begin
         if ((NOTE_SLOTS << k) < (1 << IDX_W)) begin
            if (r >= IDX_W'(NOTE_SLOTS << k)) begin
               r = r - IDX_W'(NOTE_SLOTS << k);
            end
         end
      end
      return IW'(r);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = (state_ff == ST_EMIT) && out_free;
   assign div_done   = (cnt_ff == '0);
   assign wr_slot    = slot_of(req_tdata[IDX_W-1:0]);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pos_ff, rsp_cmp_ff, rsp_period_ff};

   assign rd_freq = rd_data_ff[FREQ_W-1:0];
   assign rd_dur  = rd_data_ff[FREQ_W+DUR_W-1:FREQ_W];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == OP_TICK) && (hold_ff == '0)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = (rd_freq != '0) ? ST_PDIV : ST_EMIT;
         end
         ST_PDIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      div_load     = 1'b0;
      div_dividend = TW'(TICK_CLOCK_HZ);
      div_divisor  = rd_freq;
      mem_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            mem_we = accept && (req_tuser == OP_WRITE);
         end
         ST_FETCH: begin
            div_load = (rd_freq != '0);
         end
         ST_READ, ST_PDIV, ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // restoring divider
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[TW-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      rem_ge   = (rem_sh >= {1'b0, dvs_ff});
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      if (div_load) begin
         rem_in = '0;
         quo_in = div_dividend;
         dvs_in = div_divisor;
         cnt_in = CW'(TW);
      end else if (!div_done) begin
         rem_in = rem_ge ? rem_diff[DVW-1:0] : rem_sh[DVW-1:0];
         quo_in = {quo_ff[TW-2:0], rem_ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // player datapath
   always_comb begin
      eff_len = LW'(len_ff);
      if (len_ff == '0) begin
         eff_len = LW'(1);
      end else if (LW'(len_ff) > LW'(NOTE_SLOTS)) begin
         eff_len = LW'(NOTE_SLOTS);
      end

      dur_eff   = (rd_dur == '0) ? DUR_W'(1) : rd_dur;
      sf_eff    = (slow_ff == '0) ? SF_W'(1) : slow_ff;
      hold_prod = HOLD_W'(dur_eff) * HOLD_W'(sf_eff);

      quo_ext    = QW'(quo_ff);
      new_period = PERIOD_W'(quo_ext);
      if (quo_ext > QW'(PERIOD_MAX)) begin
         new_period = PERIOD_MAX;
      end else if (quo_ext == '0) begin
         new_period = PERIOD_W'(1);
      end

      pos_next = LW'(pos_ff) + LW'(1);
      if (pos_next >= eff_len) begin
         pos_next = '0;
      end

      slow_in        = slow_ff;
      len_in         = len_ff;
      play_pos_in    = play_pos_ff;
      pos_in         = pos_ff;
      hold_in        = hold_ff;
      last_period_in = last_period_ff;
      rest_in        = rest_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_cmp_in     = rsp_cmp_ff;
      rsp_pos_in     = rsp_pos_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLOW_FACTOR:   slow_in = csr_data[SF_W-1:0];
            CSR_MELODY_LENGTH: len_in  = csr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end

      if (accept) begin
         if (req_tuser == OP_TICK) begin
            if (hold_ff != '0) begin
               hold_in = hold_ff - 1'b1;
            end else begin
               pos_in = (LW'(play_pos_ff) >= eff_len) ? '0 : play_pos_ff;
            end
         end
      end

      if (state_ff == ST_FETCH) begin
         hold_in = hold_prod - 1'b1;
         rest_in = (rd_freq == '0);
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = POS_W'(pos_ff);
         play_pos_in  = IW'(pos_next);
         if (rest_ff) begin
            rsp_period_in = last_period_ff;
            rsp_cmp_in    = '0;
         end else begin
            rsp_period_in  = new_period;
            rsp_cmp_in     = new_period[PERIOD_W-1:1];
            last_period_in = new_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slow_ff        <= SF_W'(1);
         len_ff         <= LEN_W'(1);
         play_pos_ff    <= '0;
         hold_ff        <= '0;
         last_period_ff <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slow_ff        <= slow_in;
         len_ff         <= len_in;
         play_pos_ff    <= play_pos_in;
         hold_ff        <= hold_in;
         last_period_ff <= last_period_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      rest_ff       <= rest_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      rsp_period_ff <= rsp_period_in;
      rsp_cmp_ff    <= rsp_cmp_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   // note table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[wr_slot] <= req_tdata[IDX_W+FREQ_W+DUR_W-1:IDX_W];
      end
      rd_data_ff <= note_mem[pos_ff];
   end

`ifndef ASSERT_OFF
   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PDIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   a_hold_counts_down : assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == OP_TICK && hold_ff != '0) |=> (hold_ff == $past(hold_ff) - 1'b1))
      else $error("hold count did not step down on a held tick");

   a_result_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared outside the emit step");

   a_position_wraps : assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (LW'(play_pos_ff) < eff_len))
      else $error("play position beyond melody length");
`endif

endmodule
`default_nettype wire
